// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the off-track row detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define OTRD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, during reset as well.
`define OTRD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/otrd_pkg.sv =====
package otrd_pkg;

    // Fixed field widths.
    localparam int PIX_W   = 8;
    localparam int COUNT_W = 7;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // Run counts saturate at the top of their range.
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Register reset values.
    localparam logic [PIX_W-1:0]   WHITE_RESET = 8'd255;
    localparam logic [COUNT_W-1:0] ENTER_RESET = 7'd40;
    localparam logic [COUNT_W-1:0] EXIT_RESET  = 7'd70;

    // Register index, taken from the word address.
    typedef enum logic [1:0] {
        REG_WHITE = 2'd0,
        REG_ENTER = 2'd1,
        REG_EXIT  = 2'd2
    } t_reg_index;

    // Configuration seen by the datapath.
    typedef struct packed {
        logic [PIX_W-1:0]   white_value;
        logic [COUNT_W-1:0] enter_threshold;
        logic [COUNT_W-1:0] exit_threshold;
    } t_cfg;

    // Off-track hysteresis state.
    typedef enum logic [0:0] {
        ST_ON_TRACK  = 1'b0,
        ST_OFF_TRACK = 1'b1
    } t_track_state;

endpackage

// ===== hdl/off_track_row_detector_top.sv =====
// Channel   | Direction | Handshake         | Payload
// ----------+-----------+-------------------+-----------------------------------------
// pixel     | in        | i_valid / o_stall | i_pixel, i_row_end
// result    | out       | o_valid / i_stall | o_off_track, o_left_side, o_longest_run,
//           |           |                   | o_run_first, o_run_last
// config    | in        | APB (psel/penable)| paddr, pwdata, prdata
//
// One pixel request is taken every cycle while o_stall is low; each pixel sits in the input register
// while run tracking settles, and a row's result is loaded into the output register when its
// row-end pixel leaves the input register; o_valid then offers the result from that register.
// Reset is synchronous and active low; it clears the run state, the flag and both valids.
// A stalled result holds in the output register while pixels that do not end a row keep
// flowing; only a row-end pixel waits in the input register for a free output register.

`include "assert_macros.svh"

module off_track_row_detector_top #(
    parameter int ROW_PIXELS = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [otrd_pkg::PIX_W-1:0]    i_pixel,
    input  logic                          i_row_end,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_off_track,
    output logic                          o_left_side,
    output logic [otrd_pkg::COUNT_W-1:0]  o_longest_run,
    output logic [otrd_pkg::COUNT_W-1:0]  o_run_first,
    output logic [otrd_pkg::COUNT_W-1:0]  o_run_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [otrd_pkg::ADDR_W-1:0]   paddr,
    input  logic [otrd_pkg::DATA_W-1:0]   pwdata,
    output logic [otrd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import otrd_pkg::*;

    localparam int POS_W = $clog2(ROW_PIXELS);

    t_cfg               w_cfg;
    logic               r_in_valid;
    logic [PIX_W-1:0]   r_in_pixel;
    logic               r_in_row_end;
    logic               w_accept;
    logic               w_advance;
    logic               w_load;
    logic [COUNT_W-1:0] w_best_count;
    logic [POS_W-1:0]   w_best_start;
    logic [POS_W-1:0]   w_best_end;
    logic [POS_W-1:0]   w_last_pos;

    // A pixel advances unless it ends a row and the result register is full and stalled.
    assign w_advance = r_in_valid && (!r_in_row_end || !o_valid || !i_stall);
    assign w_load    = w_advance && r_in_row_end;
    assign o_stall   = r_in_valid && !w_advance;
    assign w_accept  = i_valid && !o_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_pixel   <= i_pixel;
            r_in_row_end <= i_row_end;
        end
    end

    otrd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    otrd_run_tracker #(
        .ROW_PIXELS (ROW_PIXELS)
    ) u_run_tracker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_advance),
        .i_pixel      (r_in_pixel),
        .i_row_end    (r_in_row_end),
        .i_white      (w_cfg.white_value),
        .o_best_count (w_best_count),
        .o_best_start (w_best_start),
        .o_best_end   (w_best_end),
        .o_last_pos   (w_last_pos)
    );

    otrd_track_flag #(
        .ROW_PIXELS (ROW_PIXELS)
    ) u_track_flag (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_load),
        .i_stall       (i_stall),
        .i_cfg         (w_cfg),
        .i_best_count  (w_best_count),
        .i_best_start  (w_best_start),
        .i_best_end    (w_best_end),
        .i_last_pos    (w_last_pos),
        .o_valid       (o_valid),
        .o_off_track   (o_off_track),
        .o_left_side   (o_left_side),
        .o_longest_run (o_longest_run),
        .o_run_first   (o_run_first),
        .o_run_last    (o_run_last)
    );

    `OTRD_ASSERT(a_result_from_row_end, i_clk, i_rst_n, $rose(o_valid) |-> $past(w_load), "result without a row-end pixel")
    `OTRD_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (!r_in_valid && !o_valid), "reset left a request pending")

endmodule

// ===== hdl/otrd_cfg_regs.sv =====
module otrd_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [otrd_pkg::ADDR_W-1:0]   paddr,
    input  logic [otrd_pkg::DATA_W-1:0]   pwdata,
    output logic [otrd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output otrd_pkg::t_cfg                o_cfg
);
    import otrd_pkg::*;

    t_cfg       r_cfg;
    t_reg_index w_index;
    logic       w_write;

    assign pready  = 1'b1;
    assign w_index = t_reg_index'(paddr[3:2]);
    assign w_write = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    // Register writes; an address past the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.white_value     <= WHITE_RESET;
            r_cfg.enter_threshold <= ENTER_RESET;
            r_cfg.exit_threshold  <= EXIT_RESET;
        end else if (w_write) begin
            unique case (w_index)
                REG_WHITE: r_cfg.white_value     <= pwdata[PIX_W-1:0];
                REG_ENTER: r_cfg.enter_threshold <= pwdata[COUNT_W-1:0];
                REG_EXIT:  r_cfg.exit_threshold  <= pwdata[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read data.
    always_comb begin
        unique case (w_index)
            REG_WHITE: prdata = DATA_W'(r_cfg.white_value);
            REG_ENTER: prdata = DATA_W'(r_cfg.enter_threshold);
            REG_EXIT:  prdata = DATA_W'(r_cfg.exit_threshold);
            default:   prdata = '0;
        endcase
    end

endmodule

// ===== hdl/otrd_run_tracker.sv =====
`include "assert_macros.svh"

module otrd_run_tracker #(
    parameter int ROW_PIXELS = 128
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_step,
    input  logic [otrd_pkg::PIX_W-1:0]         i_pixel,
    input  logic                               i_row_end,
    input  logic [otrd_pkg::PIX_W-1:0]         i_white,
    output logic [otrd_pkg::COUNT_W-1:0]       o_best_count,
    output logic [$clog2(ROW_PIXELS)-1:0]      o_best_start,
    output logic [$clog2(ROW_PIXELS)-1:0]      o_best_end,
    output logic [$clog2(ROW_PIXELS)-1:0]      o_last_pos
);
    import otrd_pkg::*;

    localparam int POS_W = $clog2(ROW_PIXELS);
    localparam int COL_W = $clog2(ROW_PIXELS + 1);

    logic               r_prev;
    logic [COL_W-1:0]   r_column;
    logic [COUNT_W-1:0] r_cur_count;
    logic [POS_W-1:0]   r_cur_start;
    logic [COUNT_W-1:0] r_best_count;
    logic [POS_W-1:0]   r_best_start;
    logic [POS_W-1:0]   r_best_end;

    logic               n_prev;
    logic [COL_W-1:0]   n_column;
    logic [COUNT_W-1:0] n_cur_count;
    logic [POS_W-1:0]   n_cur_start;
    logic [COUNT_W-1:0] n_best_count;
    logic [POS_W-1:0]   n_best_start;
    logic [POS_W-1:0]   n_best_end;

    logic               w_col_ok;
    logic               w_white;
    logic [POS_W-1:0]   w_pair_pos;
    logic [POS_W-1:0]   w_last_pos;
    logic [COUNT_W-1:0] w_fin_count;
    logic [POS_W-1:0]   w_fin_start;
    logic [POS_W-1:0]   w_fin_end;

    // Judge the pair ending at this pixel, then close the open run for row end.
    always_comb begin
        w_col_ok     = r_column < COL_W'(ROW_PIXELS);
        w_white      = i_pixel == i_white;
        w_pair_pos   = POS_W'(r_column - 1'b1);
        n_prev       = r_prev;
        n_column     = r_column;
        n_cur_count  = r_cur_count;
        n_cur_start  = r_cur_start;
        n_best_count = r_best_count;
        n_best_start = r_best_start;
        n_best_end   = r_best_end;
        if (w_col_ok) begin
            if (r_column != '0) begin
                if (r_prev && w_white) begin
                    if (n_cur_count != COUNT_MAX) begin
                        n_cur_count = n_cur_count + 1'b1;
                    end
                end else begin
                    if (r_cur_count > r_best_count) begin
                        n_best_count = r_cur_count;
                        n_best_start = r_cur_start;
                        n_best_end   = w_pair_pos;
                    end
                    n_cur_count = '0;
                    n_cur_start = w_pair_pos;
                end
            end
            n_prev   = w_white;
            n_column = r_column + 1'b1;
        end
        w_last_pos  = POS_W'(n_column - 1'b1);
        w_fin_count = n_best_count;
        w_fin_start = n_best_start;
        w_fin_end   = n_best_end;
        if (n_cur_count > n_best_count) begin
            w_fin_count = n_cur_count;
            w_fin_start = n_cur_start;
            w_fin_end   = w_last_pos;
        end
    end

    assign o_best_count = w_fin_count;
    assign o_best_start = w_fin_start;
    assign o_best_end   = w_fin_end;
    assign o_last_pos   = w_last_pos;

    // Run state; the row end restarts the row but keeps the run bounds.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev       <= 1'b0;
            r_column     <= '0;
            r_cur_count  <= '0;
            r_cur_start  <= '0;
            r_best_count <= '0;
            r_best_start <= '0;
            r_best_end   <= '0;
        end else if (i_step) begin
            if (i_row_end) begin
                r_prev       <= 1'b0;
                r_column     <= '0;
                r_cur_count  <= '0;
                r_cur_start  <= '0;
                r_best_count <= '0;
                r_best_start <= w_fin_start;
                r_best_end   <= w_fin_end;
            end else begin
                r_prev       <= n_prev;
                r_column     <= n_column;
                r_cur_count  <= n_cur_count;
                r_cur_start  <= n_cur_start;
                r_best_count <= n_best_count;
                r_best_start <= n_best_start;
                r_best_end   <= n_best_end;
            end
        end
    end

    `OTRD_ASSERT(a_column_range, i_clk, i_rst_n, r_column <= COL_W'(ROW_PIXELS), "column ran past the row length")
    `OTRD_ASSERT(a_no_pair_yet, i_clk, i_rst_n, (r_column <= COL_W'(1)) |-> (r_cur_count == '0), "run counted before the first pair")

endmodule

// ===== hdl/otrd_track_flag.sv =====
`include "assert_macros.svh"

module otrd_track_flag #(
    parameter int ROW_PIXELS = 128
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_load,
    input  logic                               i_stall,
    input  otrd_pkg::t_cfg                     i_cfg,
    input  logic [otrd_pkg::COUNT_W-1:0]       i_best_count,
    input  logic [$clog2(ROW_PIXELS)-1:0]      i_best_start,
    input  logic [$clog2(ROW_PIXELS)-1:0]      i_best_end,
    input  logic [$clog2(ROW_PIXELS)-1:0]      i_last_pos,
    output logic                               o_valid,
    output logic                               o_off_track,
    output logic                               o_left_side,
    output logic [otrd_pkg::COUNT_W-1:0]       o_longest_run,
    output logic [otrd_pkg::COUNT_W-1:0]       o_run_first,
    output logic [otrd_pkg::COUNT_W-1:0]       o_run_last
);
    import otrd_pkg::*;

    t_track_state       r_state;
    t_track_state       n_state;
    logic               r_left;
    logic               n_left;
    logic               r_valid;
    logic [COUNT_W-1:0] r_longest_run;
    logic [COUNT_W-1:0] r_run_first;
    logic [COUNT_W-1:0] r_run_last;
    logic               w_at_left;
    logic               w_at_right;

    assign w_at_left  = i_best_start == '0;
    assign w_at_right = i_best_end >= i_last_pos;

    // State register for the hysteresis flag and the remembered side.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ON_TRACK;
            r_left  <= 1'b0;
        end else if (i_load) begin
            r_state <= n_state;
            r_left  <= n_left;
        end
    end

    // Set on a short run at an edge, clear on a long run at the same edge.
    always_comb begin
        n_state = r_state;
        n_left  = r_left;
        unique case (r_state)
            ST_ON_TRACK: begin
                if (i_best_count <= i_cfg.enter_threshold) begin
                    if (w_at_left) begin
                        n_state = ST_OFF_TRACK;
                        n_left  = 1'b1;
                    end else if (w_at_right) begin
                        n_state = ST_OFF_TRACK;
                        n_left  = 1'b0;
                    end
                end
            end
            ST_OFF_TRACK: begin
                if (i_best_count >= i_cfg.exit_threshold) begin
                    if ((r_left && w_at_left) || (!r_left && w_at_right)) begin
                        n_state = ST_ON_TRACK;
                    end
                end
            end
            default: begin
                n_state = ST_ON_TRACK;
            end
        endcase
    end

    // Result register: holds a row's result until the request is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_longest_run <= i_best_count;
            r_run_first   <= COUNT_W'(i_best_start);
            r_run_last    <= COUNT_W'(i_best_end);
        end
    end

    assign o_valid       = r_valid;
    assign o_off_track   = r_state == ST_OFF_TRACK;
    assign o_left_side   = r_left;
    assign o_longest_run = r_longest_run;
    assign o_run_first   = r_run_first;
    assign o_run_last    = r_run_last;

    `OTRD_ASSERT(a_flag_on_load, i_clk, i_rst_n, (r_state != $past(r_state)) |-> $past(i_load), "flag changed without a row end")
    `OTRD_ASSERT(a_no_overwrite, i_clk, i_rst_n, (r_valid && i_stall) |-> !i_load, "stalled result overwritten")

endmodule
